@@ rtl/core/csp_pkg.sv @@
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types and character codes for the sensor frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package csp_pkg;

    localparam int BYTE_W     = 8;
    localparam int VAL_W      = 10;
    localparam int NUM_FIELDS = 6;
    localparam int FIELD_IDX_W = 3;

    localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
    localparam logic [VAL_W-1:0]  VAL_MAX    = 10'd1023;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [VAL_W-1:0] val_t;
    typedef logic [NUM_FIELDS-1:0][VAL_W-1:0] field_vec_t;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_FIELD1  = 3'd1,
        PH_FIELD2  = 3'd2,
        PH_FIELD3  = 3'd3,
        PH_FIELD4  = 3'd4,
        PH_FIELD5  = 3'd5,
        PH_FIELD6  = 3'd6,
        PH_NEWLINE = 3'd7
    } phase_t;

endpackage

`default_nettype wire

@@ rtl/core/csp_in_stage.sv @@
// ----------------------------------------------------------------------------
// csp_in_stage
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_in_stage
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire csp_pkg::byte_t rx_byte,
    input  wire logic           take,
    output logic                hold_valid,
    output csp_pkg::byte_t      hold_byte
);
    import csp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    byte_t byte_reg;

    // a new beat may enter while the held one leaves in the same cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;

endmodule

`default_nettype wire

@@ rtl/core/csp_field_parser.sv @@
// ----------------------------------------------------------------------------
// csp_field_parser
// Frame state machine, decimal accumulator and the six field registers.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_field_parser
#(
    parameter int MAX_DIGITS = 3
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire csp_pkg::byte_t ch,
    output logic                emit,
    output csp_pkg::field_vec_t fields
);
    import csp_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 2);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);

    phase_t           phase_reg;
    phase_t           phase_next;
    val_t             acc_reg;
    val_t             acc_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    field_vec_t       store_reg;

    logic [3:0]       digit;
    logic [13:0]      mac;
    val_t             mac_sat;
    val_t             field_val;
    logic             store_we;
    logic [FIELD_IDX_W-1:0] store_idx;

    always_comb
    begin
        if (ch inside {[CH_ZERO:CH_NINE]})
        begin
            digit = 4'(ch - CH_ZERO);
        end
        else
        begin
            digit = 4'd0;
        end
    end

    // acc * 10 as two shifts and an add
    assign mac       = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + {10'd0, digit};
    assign mac_sat   = (mac > {4'd0, VAL_MAX}) ? VAL_MAX : mac[VAL_W-1:0];
    assign field_val = (cnt_reg >= CNT_W'(1) && cnt_reg <= CNT_MAX) ? acc_reg : '0;
    assign store_idx = FIELD_IDX_W'(phase_reg - 3'd1);

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        store_we   = 1'b0;
        emit       = 1'b0;
        case (phase_reg)
            PH_HEADER:
            begin
                if (ch == CH_COMMA)
                begin
                    phase_next = PH_FIELD1;
                    acc_next   = '0;
                    cnt_next   = '0;
                end
            end
            PH_FIELD1, PH_FIELD2, PH_FIELD3, PH_FIELD4, PH_FIELD5, PH_FIELD6:
            begin
                if (ch == CH_COMMA)
                begin
                    store_we   = 1'b1;
                    acc_next   = '0;
                    cnt_next   = '0;
                    phase_next = phase_t'(phase_reg + 3'd1);
                end
                else
                begin
                    if (cnt_reg < CNT_MAX)
                    begin
                        acc_next = mac_sat;
                    end
                    // count saturates one past the limit to flag long fields
                    if (cnt_reg <= CNT_MAX)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            PH_NEWLINE:
            begin
                if (ch == CH_NEWLINE)
                begin
                    emit       = 1'b1;
                    phase_next = PH_HEADER;
                end
            end
            default:
            begin
                phase_next = PH_HEADER;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            acc_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && store_we)
        begin
            store_reg[store_idx] <= field_val;
        end
    end

    assign fields = store_reg;

endmodule

`default_nettype wire

@@ rtl/core/csp_out_stage.sv @@
// ----------------------------------------------------------------------------
// csp_out_stage
// Result register holding one parsed frame until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_out_stage
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire csp_pkg::field_vec_t load_fields,
    output logic                     room,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output csp_pkg::field_vec_t      fields
);
    import csp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    field_vec_t fields_reg;

    assign room       = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fields_reg <= load_fields;
        end
    end

    assign out_valid = valid_reg;
    assign fields    = fields_reg;

endmodule

`default_nettype wire

@@ rtl/core/csv_sensor_frame_parser_top.sv @@
// ----------------------------------------------------------------------------
// csv_sensor_frame_parser_top
// Parses "H,a,b,c,d,e,f," frames ended by a newline into six field values.
// ----------------------------------------------------------------------------
// One byte is accepted every cycle. A byte goes into the input register on its
// input beat, and a newline that ends a frame then loads the result register,
// which drives the output beat. The whole per-byte update (digit decode,
// multiply by ten and saturate, field store write) sits between the input
// register and the state registers. Bytes before the first comma are skipped,
// each of the six comma-ended fields is converted from up to MAX_DIGITS
// decimal characters (empty or too long fields give 0, non-digits count as 0),
// and on the newline after the sixth comma one result beat carries all six
// values. Input only stalls when a newline beat finds the result register
// still full.
`default_nettype none

module csv_sensor_frame_parser_top
#(
    parameter int MAX_DIGITS = 3
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [9:0]       cart_position,
    output logic [9:0]       cart_time,
    output logic [9:0]       pendulum_angle,
    output logic [9:0]       angle_time,
    output logic [9:0]       cart_status,
    output logic [9:0]       pendulum_status
);
    import csp_pkg::*;

    logic       hold_valid;
    byte_t      hold_byte;
    logic       take;
    logic       emit;
    logic       room;
    field_vec_t store_fields;
    field_vec_t out_fields;

    // a newline that would emit waits for room in the result register
    assign take = hold_valid && (!emit || room);

    csp_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .take       (take),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte)
    );

    csp_field_parser #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_field_parser
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (take),
        .ch     (hold_byte),
        .emit   (emit),
        .fields (store_fields)
    );

    csp_out_stage u_out_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (take && emit),
        .load_fields (store_fields),
        .room        (room),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .fields      (out_fields)
    );

    assign cart_position   = out_fields[0];
    assign cart_time       = out_fields[1];
    assign pendulum_angle  = out_fields[2];
    assign angle_time      = out_fields[3];
    assign cart_status     = out_fields[4];
    assign pendulum_status = out_fields[5];

endmodule

`default_nettype wire

@@ tb/csv_sensor_frame_parser_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_sensor_frame_parser_top_tb
// Self-checking bench for the sensor frame parser. Bytes go in one beat at a
// time, a behavioral parser predicts each six-value result, and every output
// beat is compared field by field against the oldest predicted frame.
// ----------------------------------------------------------------------------

module csv_sensor_frame_parser_top_tb;

    import csp_pkg::*;

    localparam int FIELD_DIGITS = 3;
    localparam int HOLD_LEN     = 300;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_ready;
    logic [9:0] cart_position;
    logic [9:0] cart_time;
    logic [9:0] pendulum_angle;
    logic [9:0] angle_time;
    logic [9:0] cart_status;
    logic [9:0] pendulum_status;

    // behavioral parser state
    phase_t          parse_phase;
    val_t            number_acc;
    logic [2:0]      digit_count;
    field_vec_t      field_store;

    field_vec_t      pending_frames[$];
    int              mismatch_count;
    int              bytes_sent;
    int              hold_cycles;
    bit              idle_on;
    string           field_names[NUM_FIELDS] = '{"cart_position", "cart_time",
        "pendulum_angle", "angle_time", "cart_status", "pendulum_status"};

    csv_sensor_frame_parser_top #(
        .MAX_DIGITS(FIELD_DIGITS)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .cart_position   (cart_position),
        .cart_time       (cart_time),
        .pendulum_angle  (pendulum_angle),
        .angle_time      (angle_time),
        .cart_status     (cart_status),
        .pendulum_status (pendulum_status)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #3_000_000;
        $display("csv_sensor_frame_parser_top: mismatch");
        $finish;
    end

    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("error at %0t: %s", $time, msg);
    endtask

    // advance the behavioral parser by one byte, queue a frame on its newline
    task automatic parse_byte(input byte_t ch);
        int next_acc;
        if (parse_phase == PH_HEADER)
        begin
            if (ch == CH_COMMA)
            begin
                parse_phase = PH_FIELD1;
                number_acc  = '0;
                digit_count = '0;
            end
        end
        else if (parse_phase == PH_NEWLINE)
        begin
            if (ch == CH_NEWLINE)
            begin
                pending_frames.push_back(field_store);
                parse_phase = PH_HEADER;
            end
        end
        else if (ch == CH_COMMA)
        begin
            // empty or overlong fields read as zero
            if (digit_count >= 1 && digit_count <= FIELD_DIGITS)
                field_store[parse_phase - 1] = number_acc;
            else
                field_store[parse_phase - 1] = '0;
            number_acc  = '0;
            digit_count = '0;
            parse_phase = phase_t'(parse_phase + 3'd1);
        end
        else
        begin
            if (digit_count < FIELD_DIGITS)
            begin
                next_acc = int'(number_acc) * 10;
                if (ch >= CH_ZERO && ch <= CH_NINE)
                    next_acc += int'(ch - CH_ZERO);
                number_acc = (next_acc > int'(VAL_MAX)) ? VAL_MAX : val_t'(next_acc);
            end
            if (digit_count <= FIELD_DIGITS)
                digit_count = digit_count + 3'd1;
        end
    endtask

    // one input beat; returns at the falling edge after acceptance
    task automatic send_byte(input byte_t ch);
        while (idle_on && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= ch;
        do
            @(posedge clk);
        while (!in_ready);
        parse_byte(ch);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(byte_t'(s[i]));
    endtask

    function automatic byte_t random_except(input byte_t avoid);
        byte_t b;
        do
            b = byte_t'($urandom_range(0, 255));
        while (b == avoid);
        return b;
    endfunction

    task automatic wait_results_done();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pending_frames.size() != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        // covers the path through the input and result registers plus margin
        repeat (6) @(negedge clk);
    endtask

    // well-formed frame with random content; truncate stops mid-frame
    task automatic send_random_frame(input bit truncate);
        int hdr_len;
        int cut_field;
        int len;
        int r;
        hdr_len   = $urandom_range(0, 3);
        cut_field = $urandom_range(0, NUM_FIELDS - 1);
        for (int i = 0; i < hdr_len; i++)
            send_byte(random_except(CH_COMMA));
        send_byte(CH_COMMA);
        for (int f = 0; f < NUM_FIELDS; f++)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                len = 0;
            else if (r == 1)
                len = 4;
            else if (r == 2)
                len = 5;
            else
                len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(9) != 0)
                    send_byte(CH_ZERO + byte_t'($urandom_range(0, 9)));
                else
                    send_byte(random_except(CH_COMMA));
            end
            if (truncate && f == cut_field)
                return;
            send_byte(CH_COMMA);
        end
        r = $urandom_range(0, 2);
        for (int i = 0; i < r; i++)
            send_byte(random_except(CH_NEWLINE));
        send_byte(CH_NEWLINE);
    endtask

    task automatic test_header_skip();
        send_byte(8'h00);
        send_byte(CH_NEWLINE);
        send_byte(8'hFF);
        send_text("H");
    endtask

    // full, zero, empty, overlong, non-digit and newline-in-field cases
    task automatic test_field_rules();
        send_text(",999,0,,1234,9A,");
        send_byte(CH_NEWLINE);
        send_text("5,");
        send_byte(8'hFF);
        send_byte(CH_NEWLINE);
        wait_results_done();
    endtask

    task automatic test_random_frames();
        while (bytes_sent < 500)
            send_random_frame(1'b0);
    endtask

    task automatic test_no_idle_stretch();
        idle_on = 1'b0;
        while (bytes_sent < 700)
            send_random_frame(1'b0);
        idle_on = 1'b1;
    endtask

    // receiver holds off long enough for the result register to back up input
    task automatic test_output_stall();
        idle_on     = 1'b0;
        hold_cycles = HOLD_LEN;
        repeat (6) send_random_frame(1'b0);
        idle_on = 1'b1;
        wait_results_done();
    endtask

    task automatic test_drain_pause();
        repeat (3) send_random_frame(1'b0);
        wait_results_done();
        repeat (3) send_random_frame(1'b0);
    endtask

    task automatic test_noise();
        int r;
        while (bytes_sent < 1100)
        begin
            r = $urandom_range(0, 9);
            if (r < 6)
                send_random_frame(1'b0);
            else if (r < 8)
                send_random_frame(1'b1);
            else
                repeat ($urandom_range(1, 8)) send_byte(byte_t'($urandom_range(0, 255)));
        end
    endtask

    // receiver side
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                out_ready <= !(idle_on && $urandom_range(99) < 19);
            end
        end
    end

    always @(posedge clk)
    begin
        field_vec_t got;
        field_vec_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {pendulum_status, cart_status, angle_time,
                   pendulum_angle, cart_time, cart_position};
            if (pending_frames.size() == 0)
            begin
                flag_error("result beat with no frame expected");
            end
            else
            begin
                want = pending_frames.pop_front();
                for (int k = 0; k < NUM_FIELDS; k++)
                    if (got[k] !== want[k])
                        flag_error($sformatf("%s expected %0d got %0d",
                                             field_names[k], want[k], got[k]));
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        rx_byte        = '0;
        idle_on        = 1'b1;
        hold_cycles    = 0;
        mismatch_count = 0;
        bytes_sent     = 0;
        parse_phase    = PH_HEADER;
        number_acc     = '0;
        digit_count    = '0;
        field_store    = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_header_skip();
        test_field_rules();
        test_random_frames();
        test_no_idle_stretch();
        test_output_stall();
        test_drain_pause();
        test_noise();

        wait_results_done();
        if (pending_frames.size() != 0)
            flag_error($sformatf("%0d frames never came out", pending_frames.size()));

        if (mismatch_count == 0)
            $display("csv_sensor_frame_parser_top: match");
        else
            $display("csv_sensor_frame_parser_top: mismatch");
        $finish;
    end

endmodule
